// File: rtl/core/sfl_pkg.sv
// Shared types, register indexes and arithmetic helpers for the stereo flanger.
// Used by the interfaces, the sweep generator, the channel lanes and the top level.
package sfl_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 22;

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LFO_STEP = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DELAY = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX = 3'd5;

	localparam logic signed [15:0] FB_LIMIT = 16'sd29491;
	localparam logic [15:0] MIX_FULL = 16'd32768;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic lookup;
		logic mul;
		logic addr;
		logic advance;
	} sweep_ctrl_t;

	typedef struct packed {
		logic rd;
		logic interp;
		logic prod;
		logic wr;
		logic [7:0] frac;
		logic v0;
		logic v1;
		logic signed [15:0] fb;
		logic [15:0] mix;
	} lane_ctrl_t;

	function automatic sample_t sat_sample(input logic signed [33:0] v);
		sample_t r;
		if (v > 34'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint sum;
		x = (64'(k) * 64'd1686629713) >> qbits;
		x2 = (x * x) >> 30;
		sum = longint'(x);
		t = ((x * x2) >> 30) / 64'd6;
		sum = sum - longint'(t);
		t = ((t * x2) >> 30) / 64'd20;
		sum = sum + longint'(t);
		t = ((t * x2) >> 30) / 64'd42;
		sum = sum - longint'(t);
		t = ((t * x2) >> 30) / 64'd72;
		sum = sum + longint'(t);
		t = ((t * x2) >> 30) / 64'd110;
		sum = sum - longint'(t);
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32767) begin
			sum = 64'sd32767;
		end
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		return sum[14:0];
	endfunction

endpackage

// File: rtl/core/sfl_if.sv
// Valid/ready channel interfaces for input frames and result frames.
// Depends on sfl_pkg for the sample type.
interface sfl_in_if import sfl_pkg::*; ();
	logic valid;
	logic ready;
	sample_t left_in;
	sample_t right_in;
	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sfl_out_if import sfl_pkg::*; ();
	logic valid;
	logic ready;
	sample_t left_out;
	sample_t right_out;
	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/core/sfl_sweep.sv
// LFO phase accumulator, quarter-wave sine table and delay tap address generator.
// Also keeps the ring write index and the fill flag. Depends on sfl_pkg.
module sfl_sweep import sfl_pkg::*; #(
	parameter int RING_DEPTH = 2048,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input logic clk,
	input logic arst_n,
	input sweep_ctrl_t ctl,
	input logic [21:0] lfo_step,
	input logic [16:0] min_delay,
	input logic [17:0] sweep,
	output logic [$clog2(RING_DEPTH)-1:0] rd_addr0,
	output logic [$clog2(RING_DEPTH)-1:0] rd_addr1,
	output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	output logic [7:0] frac,
	output logic v0,
	output logic v1
);
	localparam int AW = $clog2(RING_DEPTH);
	localparam int TB = $clog2(SINE_TABLE_SIZE);
	localparam int QB = TB - 2;
	localparam int QUARTER = SINE_TABLE_SIZE / 4;
	localparam int KW = QB + 1;
	localparam int PW = AW + 8;

	logic [14:0] rom [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
		localparam logic [14:0] ENTRY = sine_entry(g, QB);
		assign rom[g] = ENTRY;
	end

	logic [31:0] phase_q;
	logic [AW-1:0] wi_q;
	logic full_q;

	logic [TB-1:0] idx;
	logic [KW-1:0] k;
	logic [14:0] mag_s1;
	logic neg_s1;
	logic [15:0] u;
	logic [33:0] prod_s2;
	logic [18:0] d;
	logic [PW-1:0] pos;
	logic [AW-1:0] i0;
	logic [AW-1:0] i1;
	logic [AW-1:0] i0_q;
	logic [AW-1:0] i1_q;
	logic [7:0] frac_q;
	logic v0_q;
	logic v1_q;

	assign idx = phase_q[31 -: TB];
	assign k = idx[TB-2] ? (KW'(QUARTER) - KW'(idx[QB-1:0])) : KW'(idx[QB-1:0]);
	assign u = neg_s1 ? 16'(17'd32768 - 17'(mag_s1)) : 16'(17'd32768 + 17'(mag_s1));
	assign d = 19'(min_delay) + 19'(prod_s2[33:16]);
	assign pos = PW'({wi_q, 8'd0}) - PW'(d);
	assign i0 = pos[PW-1:8];
	assign i1 = i0 + AW'(1);

	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			mag_s1 <= rom[k];
			neg_s1 <= idx[TB-1];
		end
		if (ctl.mul) begin
			prod_s2 <= 34'(sweep) * 34'(u);
		end
		if (ctl.addr) begin
			i0_q <= i0;
			i1_q <= i1;
			frac_q <= pos[7:0];
			v0_q <= full_q | (i0 < wi_q);
			v1_q <= full_q | (i1 < wi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wi_q <= '0;
			full_q <= 1'b0;
		end else if (ctl.advance) begin
			phase_q <= phase_q + 32'(lfo_step);
			wi_q <= wi_q + AW'(1);
			if (&wi_q) begin
				full_q <= 1'b1;
			end
		end
	end

	assign rd_addr0 = i0_q;
	assign rd_addr1 = i1_q;
	assign wr_addr = wi_q;
	assign frac = frac_q;
	assign v0 = v0_q;
	assign v1 = v1_q;

endmodule

// File: rtl/core/sfl_lane.sv
// One channel lane: delay ring memory, linear interpolation, feedback write-back
// and dry/wet products. Depends on sfl_pkg.
module sfl_lane import sfl_pkg::*; #(
	parameter int RING_DEPTH = 2048
) (
	input logic clk,
	input lane_ctrl_t ctl,
	input logic [$clog2(RING_DEPTH)-1:0] rd_addr0,
	input logic [$clog2(RING_DEPTH)-1:0] rd_addr1,
	input logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	input sample_t dry,
	output sample_t result
);
	sample_t ring [RING_DEPTH];

	sample_t rd0_s1;
	sample_t rd1_s1;
	sample_t s0;
	sample_t s1;
	logic [8:0] wt1;
	logic [8:0] wt0;
	logic signed [26:0] acc;
	sample_t delayed_s2;
	logic signed [16:0] mix_s;
	logic signed [16:0] dry_wt;
	logic signed [31:0] fb_prod_s3;
	logic signed [32:0] wet_prod_s3;
	logic signed [32:0] dry_prod_s4;
	logic signed [16:0] fb_term;
	sample_t stored;
	logic signed [33:0] mix_sum;

	assign s0 = ctl.v0 ? rd0_s1 : '0;
	assign s1 = ctl.v1 ? rd1_s1 : '0;
	assign wt1 = {1'b0, ctl.frac};
	assign wt0 = 9'd256 - wt1;
	assign acc = 27'(s0) * 27'($signed({1'b0, wt0})) + 27'(s1) * 27'($signed({1'b0, wt1}))
		+ 27'sd128;
	assign mix_s = $signed({1'b0, ctl.mix});
	assign dry_wt = 17'sd32768 - mix_s;
	assign fb_term = 17'((fb_prod_s3 + 32'sd16384) >>> 15);
	assign stored = sat_sample(34'(dry) + 34'(fb_term));
	assign mix_sum = 34'(dry_prod_s4) + 34'(wet_prod_s3) + 34'sd16384;
	assign result = sat_sample(mix_sum >>> 15);

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd0_s1 <= ring[rd_addr0];
			rd1_s1 <= ring[rd_addr1];
		end
		if (ctl.wr) begin
			ring[wr_addr] <= stored;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.interp) begin
			delayed_s2 <= 16'(acc >>> 8);
		end
		if (ctl.prod) begin
			fb_prod_s3 <= delayed_s2 * ctl.fb;
			wet_prod_s3 <= 33'(delayed_s2) * 33'(mix_s);
		end
		if (ctl.wr) begin
			dry_prod_s4 <= 33'(dry) * 33'(dry_wt);
		end
	end

endmodule

// File: rtl/core/stereo_flanger_unit.sv
// Stereo flanger top level: the eight-step sequencer walks both lanes of an enabled frame
// through table lookup, delay multiply, tap address, ring read, interpolation, products,
// write-back and mixing; a frame with the effect off goes straight to the finishing step.
// A new frame is taken only in idle, once the last result is registered (this waits on
// result ready). Reset clears the sequencer, phase and write index and loads config defaults;
// the rings read as zero until written, tracked by write index and fill flag, so no clearing pass is needed.
module stereo_flanger_unit import sfl_pkg::*; #(
	parameter int RING_DEPTH = 2048,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input logic clk,
	input logic arst_n,
	sfl_in_if.sink sample_ch,
	sfl_out_if.source result_ch,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam int AW = $clog2(RING_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_INTERP = 3'd4;
	localparam logic [2:0] S_PROD = 3'd5;
	localparam logic [2:0] S_WRITE = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic enable_q;
	logic [21:0] lfo_step_q;
	logic [16:0] min_delay_q;
	logic [17:0] sweep_q;
	logic signed [15:0] fb_q;
	logic [15:0] mix_q;

	logic [2:0] state_q;
	logic bypass_q;
	sample_t left_q;
	sample_t right_q;
	logic out_valid_q;
	sample_t out_left_q;
	sample_t out_right_q;

	logic in_xfer;
	logic done_go;
	logic signed [15:0] fb_c;
	logic [15:0] mix_c;
	sweep_ctrl_t sw_ctl;
	lane_ctrl_t ln_ctl;
	logic [AW-1:0] rd_addr0;
	logic [AW-1:0] rd_addr1;
	logic [AW-1:0] wr_addr;
	logic [7:0] frac;
	logic v0;
	logic v1;
	sample_t left_res;
	sample_t right_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			lfo_step_q <= 22'd44739;
			min_delay_q <= 17'd12288;
			sweep_q <= 18'd61440;
			fb_q <= 16'sd0;
			mix_q <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_LFO_STEP: lfo_step_q <= cfg_data[21:0];
				REG_MIN_DELAY: min_delay_q <= cfg_data[16:0];
				REG_SWEEP: sweep_q <= cfg_data[17:0];
				REG_FEEDBACK: fb_q <= $signed(cfg_data[15:0]);
				REG_WET_MIX: mix_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign fb_c = (fb_q > FB_LIMIT) ? FB_LIMIT : ((fb_q < -FB_LIMIT) ? -FB_LIMIT : fb_q);
	assign mix_c = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;

	assign sample_ch.ready = (state_q == S_IDLE);
	assign in_xfer = sample_ch.valid && sample_ch.ready;
	assign done_go = (state_q == S_DONE) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bypass_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						bypass_q <= !enable_q;
						state_q <= enable_q ? S_MUL : S_DONE;
					end
				end
				S_MUL: state_q <= S_ADDR;
				S_ADDR: state_q <= S_READ;
				S_READ: state_q <= S_INTERP;
				S_INTERP: state_q <= S_PROD;
				S_PROD: state_q <= S_WRITE;
				S_WRITE: state_q <= S_DONE;
				S_DONE: begin
					if (done_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_q <= sample_ch.left_in;
			right_q <= sample_ch.right_in;
		end
		if (done_go) begin
			out_left_q <= bypass_q ? left_q : left_res;
			out_right_q <= bypass_q ? right_q : right_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.left_out = out_left_q;
	assign result_ch.right_out = out_right_q;

	assign sw_ctl.lookup = in_xfer;
	assign sw_ctl.mul = (state_q == S_MUL);
	assign sw_ctl.addr = (state_q == S_ADDR);
	assign sw_ctl.advance = done_go && !bypass_q;

	assign ln_ctl.rd = (state_q == S_READ);
	assign ln_ctl.interp = (state_q == S_INTERP);
	assign ln_ctl.prod = (state_q == S_PROD);
	assign ln_ctl.wr = (state_q == S_WRITE);
	assign ln_ctl.frac = frac;
	assign ln_ctl.v0 = v0;
	assign ln_ctl.v1 = v1;
	assign ln_ctl.fb = fb_c;
	assign ln_ctl.mix = mix_c;

	sfl_sweep #(
		.RING_DEPTH(RING_DEPTH),
		.SINE_TABLE_SIZE(SINE_TABLE_SIZE)
	) u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sw_ctl),
		.lfo_step(lfo_step_q),
		.min_delay(min_delay_q),
		.sweep(sweep_q),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.wr_addr(wr_addr),
		.frac(frac),
		.v0(v0),
		.v1(v1)
	);

	sfl_lane #(
		.RING_DEPTH(RING_DEPTH)
	) u_lane_left (
		.clk(clk),
		.ctl(ln_ctl),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.wr_addr(wr_addr),
		.dry(left_q),
		.result(left_res)
	);

	sfl_lane #(
		.RING_DEPTH(RING_DEPTH)
	) u_lane_right (
		.clk(clk),
		.ctl(ln_ctl),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.wr_addr(wr_addr),
		.dry(right_q),
		.result(right_res)
	);

`ifndef SYNTHESIS
	a_enabled_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && enable_q) |=> (state_q == S_MUL))
		else $error("Enabled frame did not enter the delay multiply step.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("Result appeared without the sequencer finishing a frame.");

	a_bypass_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(done_go && bypass_q) |=> (out_left_q == $past(left_q)
			&& out_right_q == $past(right_q)))
		else $error("Pass-through result differs from the input frame.");

	a_ring_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> (state_q == S_DONE))
		else $error("Ring write step was not followed by the finishing step.");
`endif

endmodule
